FILE: rtl/core/gsps_pkg.sv
// Package for the grid stroke point selector.
// Holds field widths, register indexes and the result type.
// No dependencies.
package gsps_pkg;

  localparam int MaxGrid    = 64;
  localparam int DiffW      = 16;
  localparam int GridW      = 7;
  localparam int ThrW       = 16;
  localparam int OffW       = 6;
  localparam int SumW       = 28;
  localparam int AreaW      = 13;
  localparam int LimitW     = 29;
  localparam int DistW      = 12;
  localparam int CfgIndexW  = 2;
  localparam int CfgDataW   = 16;

  localparam logic [CfgIndexW-1:0] RegGridSize      = 2'd0;
  localparam logic [CfgIndexW-1:0] RegErrorThreshold = 2'd1;

  localparam logic [GridW-1:0] GridReset      = 7'd8;
  localparam logic [ThrW-1:0]  ThresholdReset = 16'd100;

  typedef struct packed {
    logic            paint;
    logic [OffW-1:0] offset_x;
    logic [OffW-1:0] offset_y;
  } result_t;

endpackage

FILE: rtl/core/gsps_pixel_if.sv
// Channel interfaces of the grid stroke point selector.
// Depends on gsps_pkg for the payload widths and the result type.
interface gsps_pixel_if;
  logic                           valid;
  logic                           ready;
  logic [gsps_pkg::DiffW-1:0]     difference;

  modport source (output valid, output difference, input ready);
  modport sink (input valid, input difference, output ready);
endinterface

interface gsps_result_if;
  logic              valid;
  logic              ready;
  gsps_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/grid_stroke_point_selector_top.sv
// Top level of the grid stroke point selector.
// Depends on gsps_pkg and the channel interfaces in gsps_pixel_if.sv.
//
//   channel   direction  payload                        request taken when
//   pixel     in         difference                     valid && ready
//   result    out        paint, offset_x, offset_y      valid && ready
//   cfg       in         cfg_index, cfg_data            cfg_write
//
// One pixel is taken every cycle while the hold register can accept it. The
// last pixel of a cell is captured in a hold register when it is taken and
// moves to the result register once that is free or being read, where its
// result is offered. The threshold limit is a registered product of the
// threshold and the cell area, loaded from the threshold and area registers.
// Reset is synchronous; a stalled result holds while new pixels keep flowing
// until both the hold register and the result register are full.
module grid_stroke_point_selector_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [gsps_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [gsps_pkg::CfgDataW-1:0]      cfg_data,
  gsps_pixel_if.sink                         pixel,
  gsps_result_if.source                      result
);

  logic [gsps_pkg::GridW-1:0]   grid;
  logic [gsps_pkg::AreaW-1:0]   area;
  logic [gsps_pkg::ThrW-1:0]    threshold;
  logic [gsps_pkg::LimitW-1:0]  limit;

  logic [gsps_pkg::OffW-1:0]    column_count;
  logic [gsps_pkg::OffW-1:0]    row_count;
  logic [gsps_pkg::SumW-1:0]    error_sum;
  logic [gsps_pkg::DiffW-1:0]   best_value;
  logic [gsps_pkg::OffW-1:0]    best_x;
  logic [gsps_pkg::OffW-1:0]    best_y;
  logic [gsps_pkg::DistW-1:0]   best_distance;

  logic                         hold_valid;
  logic [gsps_pkg::SumW-1:0]    hold_sum;
  logic [gsps_pkg::OffW-1:0]    hold_x;
  logic [gsps_pkg::OffW-1:0]    hold_y;

  logic                         out_valid;
  gsps_pkg::result_t            out_data;

  logic [gsps_pkg::GridW-1:0]   grid_next;
  logic [gsps_pkg::AreaW-1:0]   area_next;
  logic [2*gsps_pkg::GridW-1:0] area_full;
  logic [gsps_pkg::LimitW:0]    limit_full;

  logic                         take;
  logic                         out_load;
  logic                         hold_move;
  logic [gsps_pkg::OffW-1:0]    centre;
  logic [gsps_pkg::OffW-1:0]    abs_dx;
  logic [gsps_pkg::OffW-1:0]    abs_dy;
  logic [2*gsps_pkg::OffW:0]    dist_full;
  logic [gsps_pkg::DistW-1:0]   pixel_dist;
  logic                         first;
  logic                         better;
  logic                         last_col;
  logic                         last_row;
  logic [gsps_pkg::SumW-1:0]    sum_next;
  logic                         paint_next;

  // Clamp the written cell side and square it for the threshold limit.
  always_comb begin
    grid_next = cfg_data[gsps_pkg::GridW-1:0];
    if (grid_next == '0) begin
      grid_next = gsps_pkg::GridW'(1);
    end else if (grid_next > gsps_pkg::GridW'(gsps_pkg::MaxGrid)) begin
      grid_next = gsps_pkg::GridW'(gsps_pkg::MaxGrid);
    end
    area_full = grid_next * grid_next;
    area_next = area_full[gsps_pkg::AreaW-1:0];
  end

  // The mean exceeds the threshold exactly when sum >= (threshold + 1) * area.
  assign limit_full = ({1'b0, threshold} + 17'd1) * area;

  assign out_load  = !out_valid || result.ready;
  assign hold_move = hold_valid && out_load;
  assign take      = pixel.valid && pixel.ready;
  assign pixel.ready = !hold_valid || out_load;

  always_comb begin
    centre = gsps_pkg::OffW'((grid - gsps_pkg::GridW'(1)) >> 1);
    abs_dx = (column_count >= centre) ? column_count - centre : centre - column_count;
    abs_dy = (row_count >= centre) ? row_count - centre : centre - row_count;
    dist_full = (2*gsps_pkg::OffW+1)'(abs_dx * abs_dx) +
                (2*gsps_pkg::OffW+1)'(abs_dy * abs_dy);
    pixel_dist = dist_full[gsps_pkg::DistW-1:0];
    first = (column_count == '0) && (row_count == '0);
    better = first || (pixel.difference > best_value) ||
             ((pixel.difference == best_value) && (pixel_dist < best_distance));
    last_col = ({1'b0, column_count} + gsps_pkg::GridW'(1)) >= grid;
    last_row = ({1'b0, row_count} + gsps_pkg::GridW'(1)) >= grid;
    sum_next = error_sum + gsps_pkg::SumW'(pixel.difference);
    paint_next = {1'b0, hold_sum} >= limit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid          <= gsps_pkg::GridReset;
      area          <= gsps_pkg::AreaW'(gsps_pkg::GridReset * gsps_pkg::GridReset);
      threshold     <= gsps_pkg::ThresholdReset;
      limit         <= '0;
      column_count  <= '0;
      row_count     <= '0;
      error_sum     <= '0;
      best_value    <= '0;
      best_x        <= '0;
      best_y        <= '0;
      best_distance <= '1;
      hold_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      limit <= limit_full[gsps_pkg::LimitW-1:0];

      if (cfg_write && cfg_index == gsps_pkg::RegGridSize) begin
        grid          <= grid_next;
        area          <= area_next;
        column_count  <= '0;
        row_count     <= '0;
        error_sum     <= '0;
        best_value    <= '0;
        best_x        <= '0;
        best_y        <= '0;
        best_distance <= '1;
      end else if (take) begin
        if (last_col && last_row) begin
          column_count  <= '0;
          row_count     <= '0;
          error_sum     <= '0;
          best_value    <= '0;
          best_x        <= '0;
          best_y        <= '0;
          best_distance <= '1;
        end else begin
          error_sum <= sum_next;
          if (last_col) begin
            column_count <= '0;
            row_count    <= row_count + gsps_pkg::OffW'(1);
          end else begin
            column_count <= column_count + gsps_pkg::OffW'(1);
          end
          if (better) begin
            best_value    <= pixel.difference;
            best_x        <= column_count;
            best_y        <= row_count;
            best_distance <= pixel_dist;
          end
        end
      end

      if (cfg_write && cfg_index == gsps_pkg::RegErrorThreshold) begin
        threshold <= cfg_data[gsps_pkg::ThrW-1:0];
      end

      if (take && last_col && last_row) begin
        hold_valid <= 1'b1;
      end else if (hold_move) begin
        hold_valid <= 1'b0;
      end

      if (out_load) begin
        out_valid <= hold_valid;
      end
    end
  end

  // Payload registers: the last pixel of a cell may still take the best spot.
  always_ff @(posedge clk) begin
    if (take && last_col && last_row) begin
      hold_sum <= sum_next;
      if (better) begin
        hold_x <= column_count;
        hold_y <= row_count;
      end else begin
        hold_x <= best_x;
        hold_y <= best_y;
      end
    end
    if (hold_move) begin
      out_data.paint    <= paint_next;
      out_data.offset_x <= paint_next ? hold_x : '0;
      out_data.offset_y <= paint_next ? hold_y : '0;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule
